>>> hw/rtl/msbr_pkg.sv
// Shared constants, types and control structs of the multi-stream bounded random unit.
`default_nettype none

package msbr_pkg;

  localparam int NUM_STREAMS  = 7;
  localparam int STREAM_IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  localparam int DOMAIN_W = 3;
  localparam int BOUND_W  = 32;
  localparam int STATE_W  = 64;
  localparam int VALUE_W  = 32;
  localparam int IN_DATA_W  = 104;  // domain + bound + load_value, padded to bytes
  localparam int OUT_DATA_W = 32;

  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam int MIX_SHIFT_A = 30;
  localparam int MIX_SHIFT_B = 27;
  localparam int MIX_SHIFT_C = 31;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_THR,
    ST_THR_WAIT,
    ST_STEP,
    ST_MUL_A,
    ST_MUL_B,
    ST_CHECK,
    ST_MOD_WAIT,
    ST_FINISH
  } msbr_state_t;

  typedef struct packed {
    logic latch_in;     // capture the input transaction
    logic load_write;   // write load_value into the named stream
    logic thr_start;    // fetch stream state, start threshold remainder
    logic thr_take;     // capture threshold from divider
    logic step;         // advance state, start first mix multiply
    logic mul_b_start;  // start second mix multiply
    logic take_n;       // capture upper half of the mixed word
    logic mod_start;    // write state back, start final remainder
    logic push_out;     // load the output register
  } msbr_cmd_t;

  typedef struct packed {
    logic is_draw;
    logic bad;          // zero bound or domain out of range
    logic div_done;
    logic mul_done;
    logic n_ok;         // candidate at or above threshold
    logic out_free;
  } msbr_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/msbr_div.sv
// Restoring 32-bit remainder unit, one quotient bit per cycle.
`default_nettype none

module msbr_div
  import msbr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [BOUND_W-1:0]   num,
  input  wire logic [BOUND_W-1:0]   den,
  output logic                      done,
  output logic [BOUND_W-1:0]        rem
);

  localparam int CNT_W = $clog2(BOUND_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [BOUND_W-1:0]   num_sh;
  logic [BOUND_W-1:0]   den_r;
  logic [BOUND_W:0]     trial;
  logic [BOUND_W:0]     diff;

  assign trial = {rem, num_sh[BOUND_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(BOUND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_r  <= den;
    end else if (busy) begin
      num_sh <= {num_sh[BOUND_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem <= diff[BOUND_W-1:0];
      end else begin
        rem <= trial[BOUND_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/msbr_mul.sv
// Low 64 bits of a 64x64 product from three 32x32 partial products.
`default_nettype none

module msbr_mul
  import msbr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [STATE_W-1:0]   a,
  input  wire logic [STATE_W-1:0]   b,
  output logic                      done,
  output logic [STATE_W-1:0]        prod
);

  localparam int HALF_W = STATE_W / 2;

  logic                 busy;
  logic [1:0]           cnt;
  logic [STATE_W-1:0]   a_r;
  logic [STATE_W-1:0]   b_r;
  logic [HALF_W-1:0]    op_x;
  logic [HALF_W-1:0]    op_y;
  logic [STATE_W-1:0]   part;

  // cnt 0: lo*lo, cnt 1: hi*lo, cnt 2: lo*hi
  assign op_x = (cnt == 2'd1) ? a_r[STATE_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign op_y = (cnt == 2'd2) ? b_r[STATE_W-1:HALF_W] : b_r[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      part <= STATE_W'(op_x) * STATE_W'(op_y);
      case (cnt)
        2'd0: ;
        2'd1: prod <= part;
        default: prod[STATE_W-1:HALF_W] <= prod[STATE_W-1:HALF_W] + part[HALF_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/msbr_ctrl.sv
// Sequencing state machine of the bounded random unit.
`default_nettype none

module msbr_ctrl
  import msbr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire msbr_status_t  status,
  output msbr_cmd_t          cmd
);

  msbr_state_t state;
  msbr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (!status.is_draw || status.bad) state_next = ST_FINISH;
        else state_next = ST_THR;
      end
      ST_THR:      state_next = ST_THR_WAIT;
      ST_THR_WAIT: if (status.div_done) state_next = ST_STEP;
      ST_STEP:     state_next = ST_MUL_A;
      ST_MUL_A:    if (status.mul_done) state_next = ST_MUL_B;
      ST_MUL_B:    if (status.mul_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.n_ok) state_next = ST_MOD_WAIT;
        else state_next = ST_STEP;
      end
      ST_MOD_WAIT: if (status.div_done) state_next = ST_FINISH;
      ST_FINISH:   if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      ST_DECODE:   cmd.load_write  = !status.is_draw;
      ST_THR:      cmd.thr_start   = 1'b1;
      ST_THR_WAIT: cmd.thr_take    = status.div_done;
      ST_STEP:     cmd.step        = 1'b1;
      ST_MUL_A:    cmd.mul_b_start = status.mul_done;
      ST_MUL_B:    cmd.take_n      = status.mul_done;
      ST_CHECK:    cmd.mod_start   = status.n_ok;
      ST_MOD_WAIT: ;
      ST_FINISH:   cmd.push_out    = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/msbr_dp.sv
// Datapath: stream states, mixing, shared multiplier and divider, output register.
`default_nettype none

module msbr_dp
  import msbr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire msbr_cmd_t               cmd,
  output msbr_status_t                 status,
  input  wire logic [IN_DATA_W-1:0]    in_data,
  input  wire logic [0:0]              in_user,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OUT_DATA_W-1:0]        out_data,
  output logic [0:0]                   out_user
);

  logic                     kind_r;
  logic [DOMAIN_W-1:0]      dom_r;
  logic [BOUND_W-1:0]       bound_r;
  logic [STATE_W-1:0]       loadv_r;

  logic [STATE_W-1:0]       streams [NUM_STREAMS];
  logic [STATE_W-1:0]       st;
  logic [VALUE_W-1:0]       thr;
  logic [VALUE_W-1:0]       n;

  logic [STREAM_IDX_W-1:0]  idx;
  logic                     dom_ok;
  logic                     bad;
  logic [STATE_W-1:0]       st_adv;
  logic [STATE_W-1:0]       mix_a;
  logic [STATE_W-1:0]       mix_b;
  logic [STATE_W-1:0]       mix_c;

  logic                     mul_start;
  logic [STATE_W-1:0]       mul_a;
  logic [STATE_W-1:0]       mul_b;
  logic                     mul_done;
  logic [STATE_W-1:0]       mul_p;

  logic                     div_start;
  logic [BOUND_W-1:0]       div_num;
  logic                     div_done;
  logic [BOUND_W-1:0]       div_rem;

  assign idx    = STREAM_IDX_W'(dom_r);
  assign dom_ok = int'(dom_r) < NUM_STREAMS;
  assign bad    = (bound_r == '0) || !dom_ok;

  assign st_adv = st + GOLDEN_STEP;
  assign mix_a  = st_adv ^ (st_adv >> MIX_SHIFT_A);
  assign mix_b  = mul_p ^ (mul_p >> MIX_SHIFT_B);
  assign mix_c  = mul_p ^ (mul_p >> MIX_SHIFT_C);

  assign mul_start = cmd.step || cmd.mul_b_start;
  assign mul_a     = cmd.step ? mix_a : mix_b;
  assign mul_b     = cmd.step ? MIX_MUL_A : MIX_MUL_B;

  // threshold is (2^32 - bound) mod bound, final answer is n mod bound
  assign div_start = cmd.thr_start || cmd.mod_start;
  assign div_num   = cmd.mod_start ? n : (BOUND_W'(0) - bound_r);

  msbr_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  msbr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (bound_r),
    .done  (div_done),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r  <= in_user[0];
      dom_r   <= in_data[DOMAIN_W-1:0];
      bound_r <= in_data[DOMAIN_W +: BOUND_W];
      loadv_r <= in_data[DOMAIN_W+BOUND_W +: STATE_W];
    end
    if (cmd.thr_start) st <= streams[idx];
    else if (cmd.step) st <= st_adv;
    if (cmd.thr_take) thr <= div_rem;
    if (cmd.take_n) n <= mix_c[STATE_W-1 -: VALUE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STREAMS; i++) begin
        streams[i] <= '0;
      end
    end else begin
      if (cmd.load_write && dom_ok) streams[idx] <= loadv_r;
      else if (cmd.mod_start) streams[idx] <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      out_user[0] <= (kind_r == KIND_DRAW) && bad;
      out_data    <= ((kind_r == KIND_DRAW) && !bad) ? div_rem : '0;
    end
  end

  always_comb begin
    status.is_draw  = (kind_r == KIND_DRAW);
    status.bad      = bad;
    status.div_done = div_done;
    status.mul_done = mul_done;
    status.n_ok     = (n >= thr);
    status.out_free = !out_valid || out_ready;
  end

  a_no_unit_clash: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push_out |-> (!out_valid || out_ready))
    else $error("output register overwritten before its transaction");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |-> (n >= thr))
    else $error("state committed for a rejected candidate");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.push_out |=> out_valid)
    else $error("pushed result not presented");

endmodule

`default_nettype wire

>>> hw/rtl/multi_stream_bounded_random_unit.sv
// Top level of the multi-stream bounded random unit: controller plus datapath.
// A load or a failed draw goes from decode straight to the output register; a draw fetches
// its stream state and threshold remainder, then runs mix rounds of step, two multiplies and
// a check until a candidate is accepted, then writes the state back and takes the remainder.
// One item at a time: the next is taken the cycle after the result is loaded, later while
// a held result blocks the output register.
// Reset (rst, synchronous, high) idles the controller and zeroes all streams.
`default_nettype none

module multi_stream_bounded_random_unit
  import msbr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] domain, [34:3] bound, [98:35] load_value, [103:99] zero
  input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,
  // [0] kind
  input  wire logic [0:0]              s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [31:0] value
  output logic [OUT_DATA_W-1:0]        m_axis_tdata,
  // [0] error
  output logic [0:0]                   m_axis_tuser
);

  msbr_cmd_t    cmd;
  msbr_status_t status;

  // controller accepts a transaction only in its idle state
  msbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath owns the output register, so results drain independently
  msbr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> sim/msbr_draw_checker.sv
// Checker for the bounded random unit: predicts each result from accepted inputs and compares.
`default_nettype none

module msbr_draw_checker
  import msbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  // [2:0] domain, [34:3] bound, [98:35] load_value, [103:99] zero
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  wire logic [0:0]            s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [31:0] value
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] error
  input  wire logic [0:0]            m_axis_tuser,
  input  wire logic                  drain_check,
  output int                         mismatches,
  output int                         outstanding,
  output int                         loads_seen,
  output int                         draws_seen,
  output int                         errors_seen,
  output int                         rejects_seen
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
  } draw_result_t;

  logic [STATE_W-1:0] stream_model [NUM_STREAMS];
  draw_result_t       awaited [$];
  draw_result_t       want;
  draw_result_t       got;
  int                 rounds;
  bit                 drain_done;

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [STATE_W-1:0] mix64(input logic [STATE_W-1:0] v);
    logic [STATE_W-1:0] m;
    m = (v ^ (v >> MIX_SHIFT_A)) * MIX_MUL_A;
    m = (m ^ (m >> MIX_SHIFT_B)) * MIX_MUL_B;
    return m ^ (m >> MIX_SHIFT_C);
  endfunction

  // Updates the stream model; rounds is the number of candidates drawn.
  task automatic predict_draw(input logic kind, input logic [DOMAIN_W-1:0] dom,
                              input logic [BOUND_W-1:0] bnd,
                              input logic [STATE_W-1:0] seed,
                              output draw_result_t res, output int n_rounds);
    logic [BOUND_W-1:0] neg;
    logic [BOUND_W-1:0] thr;
    logic [VALUE_W-1:0] cand;
    logic [STATE_W-1:0] st;
    logic [STATE_W-1:0] mixed;
    res      = '0;
    n_rounds = 0;
    if (kind == KIND_LOAD) begin
      if (dom < NUM_STREAMS) stream_model[dom] = seed;
    end else if (bnd == '0 || dom >= NUM_STREAMS) begin
      res.error = 1'b1;
    end else begin
      neg = 32'd0 - bnd;
      thr = neg % bnd;
      st  = stream_model[dom];
      do begin
        st    = st + GOLDEN_STEP;
        mixed = mix64(st);
        cand  = mixed[STATE_W-1 -: VALUE_W];
        n_rounds++;
      end while (cand < thr);
      stream_model[dom] = st;
      res.value = cand % bnd;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (stream_model[i]) stream_model[i] = '0;
      awaited.delete();
      mismatches   = 0;
      loads_seen   = 0;
      draws_seen   = 0;
      errors_seen  = 0;
      rejects_seen = 0;
      drain_done   = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata;
        got.error = m_axis_tuser[0];
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("result with none awaited: value=%h error=%b",
                                    got.value, got.error));
        end else begin
          want = awaited.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("value %h, predicted %h", got.value, want.value));
          if (got.error !== want.error)
            report_mismatch($sformatf("error flag %b, predicted %b", got.error, want.error));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_draw(s_axis_tuser[0], s_axis_tdata[DOMAIN_W-1:0],
                     s_axis_tdata[DOMAIN_W +: BOUND_W],
                     s_axis_tdata[DOMAIN_W+BOUND_W +: STATE_W], want, rounds);
        awaited.insert(awaited.size(), want);
        if (s_axis_tuser[0] == KIND_LOAD) loads_seen++;
        else draws_seen++;
        if (want.error) errors_seen++;
        if (rounds > 1) rejects_seen += rounds - 1;
      end
      if (drain_check && !drain_done) begin
        drain_done = 1'b1;
        if (awaited.size() != 0)
          report_mismatch($sformatf("%0d predicted results never arrived", awaited.size()));
      end
    end
    outstanding = awaited.size();
  end

endmodule

`default_nettype wire

>>> sim/tb_multi_stream_bounded_random_unit.sv
// Testbench top for the bounded random unit: clock, reset, stimulus and verdict.
`default_nettype none

module tb_multi_stream_bounded_random_unit
  import msbr_pkg::*;
();

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [2:0] domain, [34:3] bound, [98:35] load_value, [103:99] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // [0] kind
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [31:0] value
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] error
  logic [0:0]            m_axis_tuser;
  logic                  drain_check   = 1'b0;

  int mismatches;
  int outstanding;
  int loads_seen;
  int draws_seen;
  int errors_seen;
  int rejects_seen;

  // Idle mix of the current phase, percent of cycles.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // Nonzero asks the receive side for a hold-off of that many cycles.
  int rx_hold_req  = 0;

  localparam int ITEMS_PER_PHASE = 438;
  localparam int NUM_PHASES      = 4;
  localparam int TX_IDLE [NUM_PHASES] = '{0, 74, 0, 6};
  localparam int RX_IDLE [NUM_PHASES] = '{0, 0, 74, 6};

  multi_stream_bounded_random_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  msbr_draw_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .drain_check   (drain_check),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .loads_seen    (loads_seen),
    .draws_seen    (draws_seen),
    .errors_seen   (errors_seen),
    .rejects_seen  (rejects_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hang guard: a correct run needs a small fraction of this.
  initial begin
    #(12 * 1000000);
    $display("[multi_stream_bounded_random_unit] ERROR");
    $finish;
  end

  // Receive side: random stalls per phase, plus long hold-offs on request.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // One input transaction. Valid only drops when a gap is actually taken,
  // so back-to-back items keep it high across the edge.
  task automatic send_item(input logic kind, input logic [DOMAIN_W-1:0] dom,
                           input logic [BOUND_W-1:0] bnd, input logic [STATE_W-1:0] lv);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W-DOMAIN_W-BOUND_W-STATE_W){1'b0}}, lv, bnd, dom};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and let every predicted result come back. The count is
  // read on the falling edge, clear of the checker's update.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Mostly draws on live streams; some loads, bad domains and zero bounds.
  // Bound classes: tiny, full range, powers of two, at or just above 2^31 (heavy
  // rejection), the top of the range and mid-sized values.
  task automatic send_random_item();
    logic                kind;
    logic [DOMAIN_W-1:0] dom;
    logic [BOUND_W-1:0]  bnd;
    logic [STATE_W-1:0]  lv;
    int                  sel;
    kind = ($urandom_range(99) < 15) ? KIND_LOAD : KIND_DRAW;
    dom  = ($urandom_range(99) < 6) ? 3'd7 : DOMAIN_W'($urandom_range(NUM_STREAMS - 1));
    sel  = $urandom_range(19);
    if (sel == 0)       bnd = '0;
    else if (sel <= 6)  bnd = $urandom_range(16, 1);
    else if (sel <= 11) bnd = $urandom;
    else if (sel == 12) bnd = 32'd1 << $urandom_range(31);
    else if (sel == 13) bnd = 32'h8000_0000 + $urandom_range(1024);
    else if (sel == 14) bnd = 32'hFFFF_FFFF - $urandom_range(7);
    else                bnd = $urandom_range(1000000, 1);
    // Draws carry junk in load_value too; the block must ignore it.
    lv = {$urandom, $urandom};
    send_item(kind, dom, bnd, lv);
  endtask

  initial begin : stimulus
    logic [STATE_W-1:0] seed_tbl [NUM_STREAMS];
    seed_tbl = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF,
                 64'h8000_0000_0000_0000, 64'h1, 64'h5555_AAAA_5555_AAAA,
                 64'hFEDC_BA98_7654_3210};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    // Stream 3 drawn straight out of reset, from the all-zero state.
    send_item(KIND_DRAW, 3'd3, 32'd10, 64'h0);
    for (int d = 0; d < NUM_STREAMS; d++)
      send_item(KIND_LOAD, DOMAIN_W'(d), $urandom, seed_tbl[d]);
    // Out-of-range domain: load ignored, draw flags an error.
    send_item(KIND_LOAD, 3'd7, 32'd0, 64'hA5A5_A5A5_A5A5_A5A5);
    send_item(KIND_DRAW, 3'd7, 32'd5, 64'h0);
    // Zero bound twice: error, and the stream must not move in between.
    send_item(KIND_DRAW, 3'd1, 32'd0, 64'h0);
    send_item(KIND_DRAW, 3'd1, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    // Bound of one: zero threshold, one step, value zero.
    send_item(KIND_DRAW, 3'd1, 32'd1, 64'h0);
    send_item(KIND_DRAW, 3'd0, 32'hFFFF_FFFF, 64'h0);
    send_item(KIND_DRAW, 3'd2, 32'h8000_0000, 64'h0);
    // Just above 2^31: close to half the candidates get rejected.
    send_item(KIND_DRAW, 3'd4, 32'h8000_0001, 64'h0);
    send_item(KIND_DRAW, 3'd4, 32'h8000_0001, 64'h0);
    send_item(KIND_DRAW, 3'd5, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_DRAW, 3'd6, 32'd3, {$urandom, $urandom});
    send_item(KIND_DRAW, 3'd6, 32'hFFFF_FFFF, {$urandom, $urandom});
    wait_quiet();

    // Random part over the four idle mixes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      tx_idle_pct  = TX_IDLE[p];
      rx_stall_pct = RX_IDLE[p];
      // Long receive hold-off with a busy sender: fills the block and
      // backs up the input side.
      if (p == 0) rx_hold_req = 300;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Sender pause mid-phase until everything is back.
        if (i == ITEMS_PER_PHASE / 2) wait_quiet();
        send_random_item();
      end
      wait_quiet();
    end

    // Drain, let the pipeline settle, then flag anything still awaited.
    s_axis_tvalid <= 1'b0;
    begin : drain
      int cycles;
      cycles = 0;
      do begin
        @(negedge clk);
        cycles++;
      end while (outstanding != 0 && cycles < 50000);
    end
    repeat (16) @(posedge clk);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);

    $display("Covered %0d loads and %0d draws (%0d error results, %0d rejected candidates)",
             loads_seen, draws_seen, errors_seen, rejects_seen);
    $display("under four idle/stall mixes, a 300-cycle receive hold-off and sender pauses");
    if (mismatches == 0) begin
      $display("[multi_stream_bounded_random_unit] OK");
    end else begin
      $display("[multi_stream_bounded_random_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
